### rtl/tcmv_pkg.sv
// ----------------------------------------------------------------------------
// tcmv_pkg
// Shared widths, select codes and control/status types for the tile color
// mean and variance core.
// ----------------------------------------------------------------------------
package tcmv_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int SIDE_W      = 7;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int AREA_W      = 13;
    localparam int PIX_W       = 8;
    localparam int WORD_W      = 3 * PIX_W;
    localparam int SUM_W       = 20;
    localparam int SQ_W        = 2 * PIX_W;
    localparam int SQSUM_W     = SQ_W + 2;
    localparam int TOTAL_W     = 30;
    localparam int DIVISOR_W   = AREA_W + 1;
    localparam int DIV_CNT_W   = $clog2(TOTAL_W);
    localparam int SCORE_W     = 16;

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;
    localparam logic [1:0] SEL_SCORE = 2'd3;

    typedef struct packed {
        logic       load_en;
        logic       tile_clear;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mean_we;
        logic       scan_init;
        logic       scan_rd;
        logic       emit;
    } tcmv_cmd_t;

    typedef struct packed {
        logic last_pix;
        logic scan_last;
        logic scan_busy;
        logic div_busy;
        logic div_done;
        logic out_free;
    } tcmv_sts_t;

endpackage

### rtl/tile_color_mean_and_variance_core.sv
// ----------------------------------------------------------------------------
// tile_color_mean_and_variance_core
// Per-tile RGB mean and mean squared deviation over a square tile.
// ----------------------------------------------------------------------------
// Pixels of a tile are taken one per cycle in raster order and kept in a
// 4096-entry pixel store. After the last pixel the block stops taking
// items, computes the three channel means and the score with one shared
// restoring divider (four divisions), rescans the store at one pixel per
// cycle, and places the result in an output register. The next tile's
// pixels are accepted while the previous result waits. Writing cfg_wr_data
// sets the tile side (0 reads as 1, above 64 as 64) and drops any partial
// tile.
// ----------------------------------------------------------------------------
module tile_color_mean_and_variance_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcmv_pkg::SIDE_W-1:0]     cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcmv_pkg::PIX_W-1:0]      s_pix_red,
    input  logic [tcmv_pkg::PIX_W-1:0]      s_pix_green,
    input  logic [tcmv_pkg::PIX_W-1:0]      s_pix_blue,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcmv_pkg::PIX_W-1:0]      m_avg_red,
    output logic [tcmv_pkg::PIX_W-1:0]      m_avg_green,
    output logic [tcmv_pkg::PIX_W-1:0]      m_avg_blue,
    output logic [tcmv_pkg::AREA_W-1:0]     m_tile_area,
    output logic [tcmv_pkg::SCORE_W-1:0]    m_score
);

    tcmv_pkg::tcmv_cmd_t cmd;
    tcmv_pkg::tcmv_sts_t sts;

    tcmv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .cmd     (cmd),
        .sts     (sts)
    );

    tcmv_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_pix_red   (s_pix_red),
        .s_pix_green (s_pix_green),
        .s_pix_blue  (s_pix_blue),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_avg_red   (m_avg_red),
        .m_avg_green (m_avg_green),
        .m_avg_blue  (m_avg_blue),
        .m_tile_area (m_tile_area),
        .m_score     (m_score),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign s_ready = cmd.load_en;

endmodule

### rtl/tcmv_div.sv
// ----------------------------------------------------------------------------
// tcmv_div
// Restoring divider, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module tcmv_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [tcmv_pkg::TOTAL_W-1:0]        dividend,
    input  logic [tcmv_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                busy,
    output logic                                done,
    output logic [tcmv_pkg::TOTAL_W-1:0]        quotient
);

    logic [tcmv_pkg::DIVISOR_W-1:0] rem_reg;
    logic [tcmv_pkg::DIVISOR_W-1:0] rem_next;
    logic [tcmv_pkg::TOTAL_W-1:0]   quo_reg;
    logic [tcmv_pkg::TOTAL_W-1:0]   quo_next;
    logic [tcmv_pkg::DIVISOR_W-1:0] dsr_reg;
    logic [tcmv_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [tcmv_pkg::DIVISOR_W:0]   shifted;
    logic                           ge;

    always_comb begin
        shifted  = {rem_reg, quo_reg[tcmv_pkg::TOTAL_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        rem_next = ge ? tcmv_pkg::DIVISOR_W'(shifted - {1'b0, dsr_reg})
                      : shifted[tcmv_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[tcmv_pkg::TOTAL_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tcmv_pkg::DIV_CNT_W'(tcmv_pkg::TOTAL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/tcmv_dp.sv
// ----------------------------------------------------------------------------
// tcmv_dp
// Datapath: pixel store, channel sums, rescan squared-error pipeline,
// shared divider and result register.
// ----------------------------------------------------------------------------
module tcmv_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tcmv_pkg::SIDE_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    input  logic [tcmv_pkg::PIX_W-1:0]          s_pix_red,
    input  logic [tcmv_pkg::PIX_W-1:0]          s_pix_green,
    input  logic [tcmv_pkg::PIX_W-1:0]          s_pix_blue,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [tcmv_pkg::PIX_W-1:0]          m_avg_red,
    output logic [tcmv_pkg::PIX_W-1:0]          m_avg_green,
    output logic [tcmv_pkg::PIX_W-1:0]          m_avg_blue,
    output logic [tcmv_pkg::AREA_W-1:0]         m_tile_area,
    output logic [tcmv_pkg::SCORE_W-1:0]        m_score,
    input  tcmv_pkg::tcmv_cmd_t                 cmd,
    output tcmv_pkg::tcmv_sts_t                 sts
);

    logic [tcmv_pkg::WORD_W-1:0]    store_mem [tcmv_pkg::STORE_DEPTH];

    logic [tcmv_pkg::SIDE_W-1:0]    side_reg;
    logic [tcmv_pkg::SIDE_W-1:0]    side_next;
    logic [tcmv_pkg::AREA_W-1:0]    area;
    logic [tcmv_pkg::DIVISOR_W-1:0] area3;
    logic [tcmv_pkg::AREA_W-1:0]    count_reg;
    logic [tcmv_pkg::SUM_W-1:0]     sum_red_reg;
    logic [tcmv_pkg::SUM_W-1:0]     sum_green_reg;
    logic [tcmv_pkg::SUM_W-1:0]     sum_blue_reg;
    logic                           accept;

    logic [tcmv_pkg::PIX_W-1:0]     mean_red_reg;
    logic [tcmv_pkg::PIX_W-1:0]     mean_green_reg;
    logic [tcmv_pkg::PIX_W-1:0]     mean_blue_reg;

    logic [tcmv_pkg::ADDR_W-1:0]    scan_addr_reg;
    logic [tcmv_pkg::WORD_W-1:0]    rd_data_reg;
    logic                           p1_reg;
    logic                           p2_reg;
    logic [tcmv_pkg::SQSUM_W-1:0]   sqsum_reg;
    logic [tcmv_pkg::SQSUM_W-1:0]   sqsum_next;
    logic [tcmv_pkg::TOTAL_W-1:0]   total_reg;
    logic [tcmv_pkg::PIX_W-1:0]     dr;
    logic [tcmv_pkg::PIX_W-1:0]     dg;
    logic [tcmv_pkg::PIX_W-1:0]     db;

    logic [tcmv_pkg::TOTAL_W-1:0]   div_dividend;
    logic [tcmv_pkg::DIVISOR_W-1:0] div_divisor;
    logic                           div_busy;
    logic                           div_done;
    logic [tcmv_pkg::TOTAL_W-1:0]   div_quo;

    logic                           m_valid_reg;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_red_reg;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_green_reg;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_blue_reg;
    logic [tcmv_pkg::AREA_W-1:0]    m_tile_area_reg;
    logic [tcmv_pkg::SCORE_W-1:0]   m_score_reg;

    // side clamp at write time
    always_comb begin
        side_next = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            side_next = tcmv_pkg::SIDE_W'(1);
        end else if (cfg_wr_data > tcmv_pkg::SIDE_W'(tcmv_pkg::MAX_SIDE)) begin
            side_next = tcmv_pkg::SIDE_W'(tcmv_pkg::MAX_SIDE);
        end
    end

    assign area   = tcmv_pkg::AREA_W'(side_reg * side_reg);
    assign area3  = tcmv_pkg::DIVISOR_W'({area, 1'b0}) + tcmv_pkg::DIVISOR_W'(area);
    assign accept = s_valid && cmd.load_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg      <= tcmv_pkg::SIDE_W'(1);
            count_reg     <= '0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end else if (cfg_wr_en || cmd.tile_clear) begin
            if (cfg_wr_en) begin
                side_reg <= side_next;
            end
            count_reg     <= '0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end else if (accept) begin
            count_reg     <= count_reg + 1'b1;
            sum_red_reg   <= sum_red_reg + tcmv_pkg::SUM_W'(s_pix_red);
            sum_green_reg <= sum_green_reg + tcmv_pkg::SUM_W'(s_pix_green);
            sum_blue_reg  <= sum_blue_reg + tcmv_pkg::SUM_W'(s_pix_blue);
        end
    end

    // pixel store
    always_ff @(posedge aclk) begin
        if (accept) begin
            store_mem[count_reg[tcmv_pkg::ADDR_W-1:0]] <= {s_pix_red, s_pix_green, s_pix_blue};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_data_reg <= store_mem[scan_addr_reg];
        end
    end

    // rescan pipeline
    always_comb begin
        dr = (mean_red_reg >= rd_data_reg[23:16]) ? mean_red_reg - rd_data_reg[23:16]
                                                  : rd_data_reg[23:16] - mean_red_reg;
        dg = (mean_green_reg >= rd_data_reg[15:8]) ? mean_green_reg - rd_data_reg[15:8]
                                                   : rd_data_reg[15:8] - mean_green_reg;
        db = (mean_blue_reg >= rd_data_reg[7:0]) ? mean_blue_reg - rd_data_reg[7:0]
                                                 : rd_data_reg[7:0] - mean_blue_reg;
        sqsum_next = tcmv_pkg::SQSUM_W'(dr * dr) + tcmv_pkg::SQSUM_W'(dg * dg)
                   + tcmv_pkg::SQSUM_W'(db * db);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end else begin
            p1_reg <= cmd.scan_rd;
            p2_reg <= p1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan_rd) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (p1_reg) begin
            sqsum_reg <= sqsum_next;
        end
        if (cmd.scan_init) begin
            total_reg <= '0;
        end else if (p2_reg) begin
            total_reg <= total_reg + tcmv_pkg::TOTAL_W'(sqsum_reg);
        end
    end

    // divider operand select
    always_comb begin
        div_divisor = tcmv_pkg::DIVISOR_W'(area);
        case (cmd.div_sel)
            tcmv_pkg::SEL_RED:   div_dividend = tcmv_pkg::TOTAL_W'(sum_red_reg);
            tcmv_pkg::SEL_GREEN: div_dividend = tcmv_pkg::TOTAL_W'(sum_green_reg);
            tcmv_pkg::SEL_BLUE:  div_dividend = tcmv_pkg::TOTAL_W'(sum_blue_reg);
            default: begin
                div_dividend = total_reg;
                div_divisor  = area3;
            end
        endcase
    end

    tcmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mean_we) begin
            case (cmd.div_sel)
                tcmv_pkg::SEL_RED:   mean_red_reg   <= div_quo[tcmv_pkg::PIX_W-1:0];
                tcmv_pkg::SEL_GREEN: mean_green_reg <= div_quo[tcmv_pkg::PIX_W-1:0];
                default:             mean_blue_reg  <= div_quo[tcmv_pkg::PIX_W-1:0];
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_avg_red_reg   <= mean_red_reg;
            m_avg_green_reg <= mean_green_reg;
            m_avg_blue_reg  <= mean_blue_reg;
            m_tile_area_reg <= area;
            m_score_reg     <= div_quo[tcmv_pkg::SCORE_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_avg_red   = m_avg_red_reg;
    assign m_avg_green = m_avg_green_reg;
    assign m_avg_blue  = m_avg_blue_reg;
    assign m_tile_area = m_tile_area_reg;
    assign m_score     = m_score_reg;

    always_comb begin
        sts.last_pix  = (count_reg == tcmv_pkg::AREA_W'(area - 1'b1));
        sts.scan_last = ({1'b0, scan_addr_reg} == tcmv_pkg::AREA_W'(area - 1'b1));
        sts.scan_busy = p1_reg || p2_reg;
        sts.div_busy  = div_busy;
        sts.div_done  = div_done;
        sts.out_free  = !m_valid_reg || m_ready;
    end

endmodule

### rtl/tcmv_ctrl.sv
// ----------------------------------------------------------------------------
// tcmv_ctrl
// Sequencer: load, three mean divisions, rescan, score division, emit.
// ----------------------------------------------------------------------------
module tcmv_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output tcmv_pkg::tcmv_cmd_t     cmd,
    input  tcmv_pkg::tcmv_sts_t     sts
);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_DIV_GO    = 3'd1;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
    localparam logic [2:0] ST_SCAN      = 3'd3;
    localparam logic [2:0] ST_SCAN_WAIT = 3'd4;
    localparam logic [2:0] ST_EMIT      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                if (s_valid && sts.last_pix) begin
                    sel_next   = tcmv_pkg::SEL_RED;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    if (sel_reg == tcmv_pkg::SEL_SCORE) begin
                        state_next = ST_EMIT;
                    end else begin
                        cmd.mean_we = 1'b1;
                        if (sel_reg == tcmv_pkg::SEL_BLUE) begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end else begin
                            sel_next   = sel_reg + 1'b1;
                            state_next = ST_DIV_GO;
                        end
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                if (!sts.scan_busy) begin
                    sel_next   = tcmv_pkg::SEL_SCORE;
                    state_next = ST_DIV_GO;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.tile_clear = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sel_reg   <= tcmv_pkg::SEL_RED;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result overwritten before taken");

    a_mean_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mean_we |-> sts.div_done && $past(cmd.div_sel) == cmd.div_sel)
        else $error("mean latched without finished division");

    a_scan_follows_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_init |=> cmd.scan_rd)
        else $error("rescan did not start after init");

endmodule

### test/tile_color_mean_and_variance_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_color_mean_and_variance_core_test
// Self-checking bench for the tile color mean and variance core.
// ----------------------------------------------------------------------------
// Pixels are streamed tile by tile under several tile sides, including a side
// of zero, sides above the store limit and side changes that drop a partial
// tile. A scoreboard keeps its own copy of the tile and predicts the channel
// means, area and score of every completed tile; results are checked in order.
// Both handshakes idle at random, with a final stretch at full rate.
// ----------------------------------------------------------------------------
module tile_color_mean_and_variance_core_test;

    localparam int STALL_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_CYCLES  = 2 * tcmv_pkg::STORE_DEPTH + 300;
    localparam int RANDOM_ITEMS  = 650;

    typedef struct {
        logic [tcmv_pkg::PIX_W-1:0]   red;
        logic [tcmv_pkg::PIX_W-1:0]   green;
        logic [tcmv_pkg::PIX_W-1:0]   blue;
        logic [tcmv_pkg::AREA_W-1:0]  area;
        logic [tcmv_pkg::SCORE_W-1:0] score;
    } tile_stats_t;

    class tile_stats_scoreboard;
        int                                errors;
        int unsigned                       side;
        logic [tcmv_pkg::WORD_W-1:0]       tile_pixels[$];
        int unsigned                       sum_red;
        int unsigned                       sum_green;
        int unsigned                       sum_blue;
        tile_stats_t                       awaited[$];

        function new();
            errors = 0;
            set_side(tcmv_pkg::SIDE_W'(1));
        endfunction

        function void set_side(logic [tcmv_pkg::SIDE_W-1:0] value);
            if (value == 0) begin
                side = 1;
            end else if (value > tcmv_pkg::MAX_SIDE) begin
                side = tcmv_pkg::MAX_SIDE;
            end else begin
                side = 32'(value);
            end
            tile_pixels.delete();
            sum_red = 0;
            sum_green = 0;
            sum_blue = 0;
        endfunction

        function void note_pixel(logic [tcmv_pkg::PIX_W-1:0] r, logic [tcmv_pkg::PIX_W-1:0] g,
                                 logic [tcmv_pkg::PIX_W-1:0] b);
            int unsigned                 area;
            tile_stats_t                 stats;
            longint unsigned             total;
            int                          dr;
            int                          dg;
            int                          db;
            logic [tcmv_pkg::WORD_W-1:0] p;
            tile_pixels.push_back({r, g, b});
            sum_red += 32'(r);
            sum_green += 32'(g);
            sum_blue += 32'(b);
            area = side * side;
            if (tile_pixels.size() < area) return;
            stats.red = tcmv_pkg::PIX_W'(sum_red / area);
            stats.green = tcmv_pkg::PIX_W'(sum_green / area);
            stats.blue = tcmv_pkg::PIX_W'(sum_blue / area);
            total = 0;
            foreach (tile_pixels[i]) begin
                p = tile_pixels[i];
                dr = int'(stats.red) - int'(p[2*tcmv_pkg::PIX_W +: tcmv_pkg::PIX_W]);
                dg = int'(stats.green) - int'(p[tcmv_pkg::PIX_W +: tcmv_pkg::PIX_W]);
                db = int'(stats.blue) - int'(p[0 +: tcmv_pkg::PIX_W]);
                total += longint'(dr * dr + dg * dg + db * db);
            end
            stats.area = tcmv_pkg::AREA_W'(area);
            stats.score = tcmv_pkg::SCORE_W'(total / (3 * area));
            awaited.push_back(stats);
            tile_pixels.delete();
            sum_red = 0;
            sum_green = 0;
            sum_blue = 0;
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [tcmv_pkg::PIX_W-1:0] r,
                                   logic [tcmv_pkg::PIX_W-1:0] g,
                                   logic [tcmv_pkg::PIX_W-1:0] b,
                                   logic [tcmv_pkg::AREA_W-1:0] area,
                                   logic [tcmv_pkg::SCORE_W-1:0] score);
            tile_stats_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d",
                         $time, r, g, b, area, score);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("avg_red", 32'(want.red), 32'(r));
            compare_field("avg_green", 32'(want.green), 32'(g));
            compare_field("avg_blue", 32'(want.blue), 32'(b));
            compare_field("tile_area", 32'(want.area), 32'(area));
            compare_field("score", 32'(want.score), 32'(score));
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [tcmv_pkg::SIDE_W-1:0]    cfg_wr_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [tcmv_pkg::PIX_W-1:0]     s_pix_red = '0;
    logic [tcmv_pkg::PIX_W-1:0]     s_pix_green = '0;
    logic [tcmv_pkg::PIX_W-1:0]     s_pix_blue = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_red;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_green;
    logic [tcmv_pkg::PIX_W-1:0]     m_avg_blue;
    logic [tcmv_pkg::AREA_W-1:0]    m_tile_area;
    logic [tcmv_pkg::SCORE_W-1:0]   m_score;

    tile_stats_scoreboard tile_stats;
    int tx_idle_pct = 17;
    int rx_idle_pct = 70;
    int random_items = 0;
    int quiet_cycles = 0;

    tile_color_mean_and_variance_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pix_red   (s_pix_red),
        .s_pix_green (s_pix_green),
        .s_pix_blue  (s_pix_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_avg_red   (m_avg_red),
        .m_avg_green (m_avg_green),
        .m_avg_blue  (m_avg_blue),
        .m_tile_area (m_tile_area),
        .m_score     (m_score)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            tile_stats.check_result(m_avg_red, m_avg_green, m_avg_blue, m_tile_area, m_score);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_pixel(logic [tcmv_pkg::PIX_W-1:0] r, logic [tcmv_pkg::PIX_W-1:0] g,
                              logic [tcmv_pkg::PIX_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pix_red <= r;
        s_pix_green <= g;
        s_pix_blue <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tile_stats.note_pixel(r, g, b);
        random_items++;
    endtask

    // 0: full range, 1: narrow spread around a base color, 2: each channel 0 or 255 only
    task automatic send_styled(int unsigned count, int style);
        logic [tcmv_pkg::PIX_W-1:0] base_r;
        logic [tcmv_pkg::PIX_W-1:0] base_g;
        logic [tcmv_pkg::PIX_W-1:0] base_b;
        base_r = tcmv_pkg::PIX_W'($urandom_range(0, 252));
        base_g = tcmv_pkg::PIX_W'($urandom_range(0, 252));
        base_b = tcmv_pkg::PIX_W'($urandom_range(0, 252));
        for (int unsigned i = 0; i < count; i++) begin
            case (style)
                1: begin
                    send_pixel(base_r + tcmv_pkg::PIX_W'($urandom_range(0, 3)),
                               base_g + tcmv_pkg::PIX_W'($urandom_range(0, 3)),
                               base_b + tcmv_pkg::PIX_W'($urandom_range(0, 3)));
                end
                2: begin
                    send_pixel({tcmv_pkg::PIX_W{$urandom_range(0, 1) == 1}},
                               {tcmv_pkg::PIX_W{$urandom_range(0, 1) == 1}},
                               {tcmv_pkg::PIX_W{$urandom_range(0, 1) == 1}});
                end
                default: begin
                    send_pixel(tcmv_pkg::PIX_W'($urandom), tcmv_pkg::PIX_W'($urandom),
                               tcmv_pkg::PIX_W'($urandom));
                end
            endcase
        end
    endtask

    // side changes only once all results are out and the block has settled
    task automatic write_side(logic [tcmv_pkg::SIDE_W-1:0] value);
        s_valid <= 1'b0;
        while (tile_stats.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tile_stats.set_side(value);
    endtask

    task automatic set_idle(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    initial begin
        int unsigned                 area;
        int unsigned                 tiles;
        int unsigned                 remaining;
        int                          pick;
        logic [tcmv_pkg::SIDE_W-1:0] side_value;
        tile_stats = new();
        set_idle(17, 70);
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // single-pixel tiles at the extremes
        write_side(tcmv_pkg::SIDE_W'(1));
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd170);
        send_pixel(8'd0, 8'd255, 8'd85);
        // zero side acts as one
        write_side(tcmv_pkg::SIDE_W'(0));
        send_pixel(8'd1, 8'd2, 8'd4);
        send_pixel(8'd128, 8'd64, 8'd32);
        // black and white checkerboard, high score
        write_side(tcmv_pkg::SIDE_W'(2));
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        // partial tile dropped by a side change
        write_side(tcmv_pkg::SIDE_W'(3));
        send_pixel(8'd17, 8'd34, 8'd51);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd50);
        write_side(tcmv_pkg::SIDE_W'(2));
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);

        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                set_idle(17, 70);
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                set_idle(70, 17);
            end else begin
                set_idle(0, 0);
            end
            remaining = RANDOM_ITEMS - random_items;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                side_value = '0;
            end else if (pick == 1 && remaining >= 256) begin
                side_value = tcmv_pkg::SIDE_W'($urandom_range(9, 16));
            end else begin
                side_value = tcmv_pkg::SIDE_W'($urandom_range(1, 8));
            end
            write_side(side_value);
            area = tile_stats.side * tile_stats.side;
            tiles = (tile_stats.side > 8) ? 1 : $urandom_range(1, 4);
            while (tiles > 1 && tiles * area > remaining) tiles--;
            repeat (tiles) send_styled(area, $urandom_range(0, 2));
            if (area > 1 && remaining >= (tiles + 1) * area && $urandom_range(0, 3) == 0) begin
                send_styled($urandom_range(1, area - 1), 0);
            end
        end

        // largest and saturated sides: partial tiles that are dropped
        set_idle(0, 0);
        write_side(tcmv_pkg::SIDE_W'(tcmv_pkg::MAX_SIDE));
        send_styled($urandom_range(1, 40), 0);
        write_side('1);
        send_styled($urandom_range(1, 40), 0);
        write_side(tcmv_pkg::SIDE_W'(2));
        send_styled(4, 0);

        s_valid <= 1'b0;
        while (tile_stats.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tile_stats.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
rtl/tcmv_pkg.sv
rtl/tcmv_div.sv
rtl/tcmv_dp.sv
rtl/tcmv_ctrl.sv
rtl/tile_color_mean_and_variance_core.sv
test/tile_color_mean_and_variance_core_test.sv
